[src/i2cbs_pkg.sv]
// Shared types and constants for the I2C master byte sequencer.
package i2cbs_pkg;

  // Command codes as they arrive on the input tuser
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  // Item classes produced by the front end
  localparam logic [1:0] KIND_NOP  = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Sequencer operation codes
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;

  // Pin phases within one bit slot
  localparam logic [1:0] PH_DRIVE = 2'd0;
  localparam logic [1:0] PH_RISE  = 2'd1;
  localparam logic [1:0] PH_FALL  = 2'd2;

  // Queue between front end and sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Classified item passed from front end to sequencer
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // Result item carried on the output channel
  typedef struct packed {
    logic       rejected;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

[src/i2c_master_byte_sequencer_core.sv]
// I2C master byte sequencer: an accepted item passes through the front register, the queue and the output register.
// Throughput is one item per clock; the front register, the two-entry queue and
// the sequencer with its output register each stall independently on backpressure.
// The sequencer state updates in the single cycle an item leaves the queue.
// Synchronous active-high reset idles the sequencer with SCL and SDA released
// and empties the front register, the queue and the output register.
module i2c_master_byte_sequencer_core #(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
  input  logic [7:0]  s_tuser,   // func[2:0], zero[7:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                 // rx_byte[11:4], nack_seen[12], rejected[13], zero[15:14]
);

  logic                 push;
  logic                 push_ready;
  i2cbs_pkg::item_t     push_item;
  logic                 pop_valid;
  logic                 pop;
  i2cbs_pkg::item_t     pop_item;
  i2cbs_pkg::result_t   result;

  // Accept and classify items
  i2cbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Buffer classified items
  i2cbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  // Run the pin sequence
  i2cbs_back #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_result  (result)
  );

  assign m_tdata = {2'b00, 14'(result)};

endmodule

[src/i2cbs_front.sv]
// Front end: accept input items, classify the command code, register them.
module i2cbs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
  input  logic [7:0]          s_tuser,   // func[2:0], zero[7:3]
  output logic                push,
  output i2cbs_pkg::item_t    push_item,
  input  logic                push_ready
);

  logic             stage_valid;
  i2cbs_pkg::item_t stage_item;
  i2cbs_pkg::item_t decoded;

  // Classify the command code
  always_comb begin
    decoded.func     = s_tuser[2:0];
    decoded.tx_byte  = s_tdata[7:0];
    decoded.send_ack = s_tdata[8];
    decoded.sda_in   = s_tdata[9];
    unique case (s_tuser[2:0]) inside
      i2cbs_pkg::FUNC_START, i2cbs_pkg::FUNC_STOP,
      i2cbs_pkg::FUNC_WRITE, i2cbs_pkg::FUNC_READ: decoded.kind = i2cbs_pkg::KIND_CMD;
      i2cbs_pkg::FUNC_TICK:                         decoded.kind = i2cbs_pkg::KIND_TICK;
      default:                                      decoded.kind = i2cbs_pkg::KIND_NOP;
    endcase
  end

  assign s_tready  = !stage_valid || push_ready;
  assign push      = stage_valid;
  assign push_item = stage_item;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_item <= decoded;
    end
  end

endmodule

[src/i2cbs_queue.sv]
// Two-entry queue decoupling the front end from the sequencer.
module i2cbs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cbs_pkg::item_t push_item,
  output logic             push_ready,
  output logic             pop_valid,
  output i2cbs_pkg::item_t pop_item,
  input  logic             pop
);

  i2cbs_pkg::item_t                  entries [i2cbs_pkg::QUEUE_DEPTH];
  logic [i2cbs_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [i2cbs_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [i2cbs_pkg::QUEUE_CNT_W-1:0] count;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = count != i2cbs_pkg::QUEUE_CNT_W'(i2cbs_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[src/i2cbs_back.sv]
// Back end: pin sequencer state machine and output result register.
module i2cbs_back #(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  i2cbs_pkg::item_t pop_item,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output i2cbs_pkg::result_t m_result
);

  localparam int IDX_W = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;

  logic [2:0]       op_kind,    op_kind_next;
  logic [IDX_W-1:0] bit_index,  bit_index_next;
  logic [1:0]       sub_phase,  sub_phase_next;
  logic [7:0]       shift_reg,  shift_reg_next;
  logic             scl_level,  scl_level_next;
  logic             sda_level,  sda_level_next;
  logic             ack_choice, ack_choice_next;
  logic             done;
  logic             rej;
  logic [7:0]       rx;
  logic             nack;
  logic             last_bit;

  assign pop      = pop_valid && (!m_tvalid || m_tready);
  assign last_bit = bit_index == IDX_W'(BITS_PER_BYTE - 1);

  // Work out the next sequencer state for the item at the queue head
  always_comb begin
    op_kind_next    = op_kind;
    bit_index_next  = bit_index;
    sub_phase_next  = sub_phase;
    shift_reg_next  = shift_reg;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_choice_next = ack_choice;
    done = 1'b0;
    rej  = 1'b0;
    rx   = '0;
    nack = 1'b0;
    if (pop) begin
      case (pop_item.kind)
        i2cbs_pkg::KIND_CMD: begin
          if (op_kind != i2cbs_pkg::OP_IDLE) begin
            rej = 1'b1;
          end else begin
            bit_index_next = '0;
            sub_phase_next = i2cbs_pkg::PH_DRIVE;
            unique case (pop_item.func)
              i2cbs_pkg::FUNC_START: op_kind_next = i2cbs_pkg::OP_START;
              i2cbs_pkg::FUNC_STOP:  op_kind_next = i2cbs_pkg::OP_STOP;
              i2cbs_pkg::FUNC_WRITE: begin
                op_kind_next   = i2cbs_pkg::OP_WRITE;
                shift_reg_next = pop_item.tx_byte;
              end
              default: begin
                op_kind_next    = i2cbs_pkg::OP_READ;
                shift_reg_next  = '0;
                ack_choice_next = pop_item.send_ack;
              end
            endcase
          end
        end
        i2cbs_pkg::KIND_TICK: begin
          if (op_kind != i2cbs_pkg::OP_IDLE) begin
            unique case (op_kind)
              i2cbs_pkg::OP_START: begin
                if (sub_phase == i2cbs_pkg::PH_DRIVE) begin
                  scl_level_next = 1'b1;
                end else if (sub_phase == i2cbs_pkg::PH_RISE) begin
                  sda_level_next = 1'b0;
                end else begin
                  scl_level_next = 1'b0;
                  done = 1'b1;
                end
              end
              i2cbs_pkg::OP_STOP: begin
                if (sub_phase == i2cbs_pkg::PH_DRIVE) begin
                  sda_level_next = 1'b0;
                end else if (sub_phase == i2cbs_pkg::PH_RISE) begin
                  scl_level_next = 1'b1;
                end else begin
                  sda_level_next = 1'b1;
                  done = 1'b1;
                end
              end
              i2cbs_pkg::OP_WRITE: begin
                if (sub_phase == i2cbs_pkg::PH_DRIVE) begin
                  sda_level_next = shift_reg[7];
                end else if (sub_phase == i2cbs_pkg::PH_RISE) begin
                  scl_level_next = 1'b1;
                end else begin
                  scl_level_next = 1'b0;
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                  if (last_bit) begin
                    op_kind_next   = i2cbs_pkg::OP_WACK;
                    bit_index_next = '0;
                  end else begin
                    bit_index_next = bit_index + 1'b1;
                  end
                end
              end
              i2cbs_pkg::OP_READ: begin
                if (sub_phase == i2cbs_pkg::PH_DRIVE) begin
                  sda_level_next = 1'b1;
                end else if (sub_phase == i2cbs_pkg::PH_RISE) begin
                  scl_level_next = 1'b1;
                end else begin
                  scl_level_next = 1'b0;
                  shift_reg_next = {shift_reg[6:0], pop_item.sda_in};
                  if (last_bit) begin
                    op_kind_next   = i2cbs_pkg::OP_RACK;
                    bit_index_next = '0;
                  end else begin
                    bit_index_next = bit_index + 1'b1;
                  end
                end
              end
              i2cbs_pkg::OP_WACK: begin
                if (sub_phase == i2cbs_pkg::PH_DRIVE) begin
                  sda_level_next = 1'b1;
                end else if (sub_phase == i2cbs_pkg::PH_RISE) begin
                  scl_level_next = 1'b1;
                end else begin
                  scl_level_next = 1'b0;
                  done = 1'b1;
                  nack = pop_item.sda_in;
                end
              end
              default: begin
                if (sub_phase == i2cbs_pkg::PH_DRIVE) begin
                  sda_level_next = !ack_choice;
                end else if (sub_phase == i2cbs_pkg::PH_RISE) begin
                  scl_level_next = 1'b1;
                end else begin
                  scl_level_next = 1'b0;
                  done = 1'b1;
                  rx = shift_reg;
                end
              end
            endcase
            // Close the command or step to the next phase
            if (done) begin
              op_kind_next   = i2cbs_pkg::OP_IDLE;
              sub_phase_next = i2cbs_pkg::PH_DRIVE;
              bit_index_next = '0;
            end else if (sub_phase == i2cbs_pkg::PH_FALL) begin
              sub_phase_next = i2cbs_pkg::PH_DRIVE;
            end else begin
              sub_phase_next = sub_phase + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Update sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      op_kind    <= i2cbs_pkg::OP_IDLE;
      bit_index  <= '0;
      sub_phase  <= i2cbs_pkg::PH_DRIVE;
      shift_reg  <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_choice <= 1'b0;
    end else begin
      op_kind    <= op_kind_next;
      bit_index  <= bit_index_next;
      sub_phase  <= sub_phase_next;
      shift_reg  <= shift_reg_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_choice <= ack_choice_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_result.scl_out   <= scl_level_next;
      m_result.sda_out   <= sda_level_next;
      m_result.busy_res  <= op_kind_next != i2cbs_pkg::OP_IDLE;
      m_result.done_res  <= done;
      m_result.rx_byte   <= rx;
      m_result.nack_seen <= nack;
      m_result.rejected  <= rej;
    end
  end

endmodule

[src/i2cbs_checker.sv]
// Port-level checker for the I2C master byte sequencer, bound to the top level.
module i2cbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Finishing a command leaves the sequencer idle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done reported while still busy");

  // A rejected command can only happen while busy, and never finishes anything
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> m_tdata[2] && !m_tdata[3])
    else $error("rejection without a busy sequencer");

  // Read byte and ack status appear only with done
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:4] != 8'h00 || m_tdata[12]) |-> m_tdata[3])
    else $error("read byte or nack without completion");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind i2c_master_byte_sequencer_core i2cbs_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[test/tb_i2c_master_byte_sequencer_core.sv]
// Self-checking testbench for the I2C master byte sequencer core.
module tb_i2c_master_byte_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BITS_PER_BYTE = 8;
  localparam int PIN_TICKS     = 3;
  localparam int BYTE_TICKS    = 3 * BITS_PER_BYTE + 3;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 200000;

  // Function codes outside the command set; the block treats them as no-ops
  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  // Known results: {rejected, nack_seen, rx_byte, done_res, busy_res, sda_out, scl_out}
  localparam i2cbs_pkg::result_t R_IDLE   = {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam i2cbs_pkg::result_t R_LOADED = {1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
  localparam i2cbs_pkg::result_t R_REJECT = {1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

  typedef struct {
    logic [2:0]         func;
    logic [7:0]         tx;
    logic               sack;
    logic               sda;
    int                 reps;
    bit                 typed;
    i2cbs_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [7:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // Expectation carried alongside the item on the input side
  bit                 cur_typed = 1'b0;
  i2cbs_pkg::result_t cur_want = '0;

  i2cbs_pkg::result_t bus_results[$];
  stim_row_t   plan[$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          cycle_cnt = 0;
  bit          hold_req = 1'b0;

  // Sequencer state mirror
  logic [2:0]  seq_op;
  logic [3:0]  seq_bit;
  logic [1:0]  seq_phase;
  logic [7:0]  seq_shift;
  logic        scl_q;
  logic        sda_q;
  logic        ack_drive;
  logic        ack_sample;

  i2c_master_byte_sequencer_core #(
    .BITS_PER_BYTE(BITS_PER_BYTE)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reset the pin sequencer mirror
  task automatic bus_reset();
    seq_op     = i2cbs_pkg::OP_IDLE;
    seq_bit    = '0;
    seq_phase  = i2cbs_pkg::PH_DRIVE;
    seq_shift  = '0;
    scl_q      = 1'b1;
    sda_q      = 1'b1;
    ack_drive  = 1'b0;
    ack_sample = 1'b0;
  endtask

  // Apply one item to the mirror and return the pin/status result it causes
  function automatic i2cbs_pkg::result_t advance_bus(logic [2:0] f, logic [7:0] tx,
                                                     logic sack, logic sdai);
    i2cbs_pkg::result_t r;
    logic               fin;
    logic [1:0]         ph;
    r   = '0;
    fin = 1'b0;
    if (f <= i2cbs_pkg::FUNC_READ) begin
      if (seq_op != i2cbs_pkg::OP_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        seq_bit   = '0;
        seq_phase = i2cbs_pkg::PH_DRIVE;
        case (f)
          i2cbs_pkg::FUNC_START: seq_op = i2cbs_pkg::OP_START;
          i2cbs_pkg::FUNC_STOP:  seq_op = i2cbs_pkg::OP_STOP;
          i2cbs_pkg::FUNC_WRITE: begin
            seq_op    = i2cbs_pkg::OP_WRITE;
            seq_shift = tx;
          end
          default: begin
            seq_op    = i2cbs_pkg::OP_READ;
            seq_shift = '0;
            ack_drive = sack;
          end
        endcase
      end
    end else if (f == i2cbs_pkg::FUNC_TICK && seq_op != i2cbs_pkg::OP_IDLE) begin
      ph = seq_phase;
      case (seq_op)
        i2cbs_pkg::OP_START: begin
          if (ph == i2cbs_pkg::PH_DRIVE) scl_q = 1'b1;
          else if (ph == i2cbs_pkg::PH_RISE) sda_q = 1'b0;
          else begin
            scl_q = 1'b0;
            fin   = 1'b1;
          end
        end
        i2cbs_pkg::OP_STOP: begin
          if (ph == i2cbs_pkg::PH_DRIVE) sda_q = 1'b0;
          else if (ph == i2cbs_pkg::PH_RISE) scl_q = 1'b1;
          else begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        end
        i2cbs_pkg::OP_WRITE: begin
          if (ph == i2cbs_pkg::PH_DRIVE) sda_q = seq_shift[7];
          else if (ph == i2cbs_pkg::PH_RISE) scl_q = 1'b1;
          else begin
            scl_q     = 1'b0;
            seq_shift = {seq_shift[6:0], 1'b0};
            if (int'(seq_bit) + 1 >= BITS_PER_BYTE) begin
              seq_op  = i2cbs_pkg::OP_WACK;
              seq_bit = '0;
            end else begin
              seq_bit = seq_bit + 4'd1;
            end
          end
        end
        i2cbs_pkg::OP_READ: begin
          if (ph == i2cbs_pkg::PH_DRIVE) sda_q = 1'b1;
          else if (ph == i2cbs_pkg::PH_RISE) scl_q = 1'b1;
          else begin
            seq_shift = {seq_shift[6:0], sdai};
            scl_q     = 1'b0;
            if (int'(seq_bit) + 1 >= BITS_PER_BYTE) begin
              seq_op  = i2cbs_pkg::OP_RACK;
              seq_bit = '0;
            end else begin
              seq_bit = seq_bit + 4'd1;
            end
          end
        end
        i2cbs_pkg::OP_WACK: begin
          if (ph == i2cbs_pkg::PH_DRIVE) sda_q = 1'b1;
          else if (ph == i2cbs_pkg::PH_RISE) scl_q = 1'b1;
          else begin
            ack_sample  = sdai;
            scl_q       = 1'b0;
            fin         = 1'b1;
            r.nack_seen = ack_sample;
          end
        end
        default: begin
          // read ack slot: drive low for ack, release for nak
          if (ph == i2cbs_pkg::PH_DRIVE) sda_q = !ack_drive;
          else if (ph == i2cbs_pkg::PH_RISE) scl_q = 1'b1;
          else begin
            scl_q     = 1'b0;
            fin       = 1'b1;
            r.rx_byte = seq_shift;
          end
        end
      endcase
      if (fin) begin
        seq_op    = i2cbs_pkg::OP_IDLE;
        seq_phase = i2cbs_pkg::PH_DRIVE;
        seq_bit   = '0;
      end else begin
        seq_phase = (ph == i2cbs_pkg::PH_FALL) ? i2cbs_pkg::PH_DRIVE : ph + 2'd1;
      end
    end
    r.scl_out  = scl_q;
    r.sda_out  = sda_q;
    r.busy_res = (seq_op != i2cbs_pkg::OP_IDLE);
    r.done_res = fin;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_seen, what, got, want);
  endtask

  task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Check results as they leave, then queue the expectation for each accepted item
  always @(posedge clk) begin
    i2cbs_pkg::result_t got;
    i2cbs_pkg::result_t want;
    i2cbs_pkg::result_t predicted;
    if (!rst && m_tvalid && m_tready) begin
      if (bus_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata[7:0], 8'h00);
      end else begin
        want = bus_results.pop_front();
        got  = i2cbs_pkg::result_t'(m_tdata[13:0]);
        compare_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
        compare_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
        compare_field("rx_byte", got.rx_byte, want.rx_byte);
        compare_field("nack_seen", 8'(got.nack_seen), 8'(want.nack_seen));
        compare_field("rejected", 8'(got.rejected), 8'(want.rejected));
      end
      results_seen++;
    end
    if (!rst && s_tvalid && s_tready) begin
      predicted = advance_bus(s_tuser[2:0], s_tdata[7:0], s_tdata[8], s_tdata[9]);
      bus_results.push_back(cur_typed ? cur_want : predicted);
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: stall in random modes, with one long hold-off on request
  initial begin : ready_ctl
    int mode;
    int mode_left;
    int hold_cnt;
    mode      = 0;
    mode_left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_item(logic [2:0] f, logic [7:0] tx, logic sack, logic sda,
                           bit typed, i2cbs_pkg::result_t want);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= {5'b0, f};
    s_tdata   <= {6'b0, sda, sack, tx};
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Hold the input idle until every expected result has come back
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (bus_results.size() != 0);
  endtask

  task automatic send_tick(logic sda);
    send_item(i2cbs_pkg::FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              sda, 1'b0, '0);
  endtask

  // One well-formed command with its ticks, with the odd stray item mixed in
  task automatic run_transfer();
    logic [2:0] f;
    int         n;
    f = 3'($urandom_range(i2cbs_pkg::FUNC_START, i2cbs_pkg::FUNC_READ));
    send_item(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'b0, '0);
    n = (f == i2cbs_pkg::FUNC_START || f == i2cbs_pkg::FUNC_STOP) ? PIN_TICKS : BYTE_TICKS;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(3'($urandom_range(i2cbs_pkg::FUNC_START, i2cbs_pkg::FUNC_READ)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      if ($urandom_range(0, 29) == 0)
        send_item(3'($urandom_range(FUNC_SPARE5, FUNC_SPARE7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      send_tick(1'($urandom_range(0, 1)));
    end
  endtask

  // A few arbitrary items, then enough ticks to finish whatever they started
  task automatic run_noise();
    int k;
    k = $urandom_range(1, 4);
    repeat (k)
      send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
    repeat (BYTE_TICKS) send_tick(1'($urandom_range(0, 1)));
  endtask

  function automatic stim_row_t plan_row(logic [2:0] f, logic [7:0] tx, logic sack,
                                         logic sda, int reps, bit typed,
                                         i2cbs_pkg::result_t want);
    stim_row_t r;
    r.func  = f;
    r.tx    = tx;
    r.sack  = sack;
    r.sda   = sda;
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    bus_reset();

    // Directed items: idle behavior, spare codes, rejection, byte extremes
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b0, 1, 1'b1, R_IDLE));
    plan.push_back(plan_row(FUNC_SPARE5,           8'hFF, 1'b1, 1'b1, 1, 1'b1, R_IDLE));
    plan.push_back(plan_row(FUNC_SPARE6,           8'h00, 1'b0, 1'b0, 1, 1'b1, R_IDLE));
    plan.push_back(plan_row(FUNC_SPARE7,           8'hFF, 1'b1, 1'b1, 1, 1'b1, R_IDLE));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_START, 8'h00, 1'b0, 1'b0, 1, 1'b1, R_LOADED));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_STOP,  8'hFF, 1'b1, 1'b1, 1, 1'b1, R_REJECT));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b0, PIN_TICKS, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_WRITE, 8'hFF, 1'b0, 1'b0, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b1, BYTE_TICKS, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_WRITE, 8'h00, 1'b1, 1'b1, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'hFF, 1'b1, 1'b0, BYTE_TICKS, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_READ,  8'h00, 1'b1, 1'b0, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b1, BYTE_TICKS, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_READ,  8'hFF, 1'b0, 1'b1, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b0, BYTE_TICKS, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_WRITE, 8'hA5, 1'b0, 1'b0, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b1, 10, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_READ,  8'h3C, 1'b1, 1'b0, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_WRITE, 8'h5A, 1'b0, 1'b1, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b0, BYTE_TICKS - 10,
                            1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b0, 1, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'h00, 1'b0, 1'b0, PIN_TICKS, 1'b0, '0));
    plan.push_back(plan_row(i2cbs_pkg::FUNC_TICK,  8'hFF, 1'b1, 1'b1, 1, 1'b1, R_IDLE));

    // Hold reset, then release on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      repeat (plan[i].reps)
        send_item(plan[i].func, plan[i].tx, plan[i].sack, plan[i].sda,
                  plan[i].typed, plan[i].want);
    drain_results();

    // Random part: mostly whole transfers, some noise
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent > RANDOM_ITEMS / 2) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && items_sent > (RANDOM_ITEMS * 3) / 4) begin
        pause_done = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 99) < 85) run_transfer();
      else run_noise();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
src/i2cbs_pkg.sv
src/i2cbs_front.sv
src/i2cbs_queue.sv
src/i2cbs_back.sv
src/i2c_master_byte_sequencer_core.sv
src/i2cbs_checker.sv
test/tb_i2c_master_byte_sequencer_core.sv
